// File: rtl/jsu_pkg.sv
// jsu_pkg: shared types, command and status codes for the JSON string unescaper.
// No dependencies; used by every module under rtl/.
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

  localparam logic [2:0] CMD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_UTF8   = 3'd1;
  localparam logic [2:0] CMD_CLOSE  = 3'd2;
  localparam logic [2:0] CMD_UNTERM = 3'd3;
  localparam logic [2:0] CMD_BADESC = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
  } cmd_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_ESC = 2'd1;
  localparam logic [1:0] STATUS_UNTERM  = 2'd2;

  // {is_hex, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: rtl/json_string_unescape_utf8.sv
// json_string_unescape_utf8: top level; front classifier, command queue, result expander.
// Depends on jsu_pkg, jsu_front, jsu_fifo, jsu_back.
//
//   channel | dir | handshake              | payload
//   in_     | in  | in_valid / in_ready    | in_data  (jsu_pkg::in_item_t)
//   out_    | out | out_valid / out_ready  | out_data (jsu_pkg::out_item_t)
//   cfg_    | in  | cfg_valid / cfg_ready  | cfg_data (single_quote_mode)
//
// One input byte per cycle; results leave at one per cycle from the output register.
// Output stalls while out_ready is low; a \u escape gives up to three results.
// in_ready drops only while the command queue is full; cfg_ready is always high.
// Reset is synchronous, active low; no clearing pass.
module json_string_unescape_utf8 #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jsu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jsu_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic          q_full;
  logic          push;
  logic          pop;
  logic          head_valid;
  jsu_pkg::cmd_t cmd;
  jsu_pkg::cmd_t head;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_valid && in_ready),
    .in_item  (in_data),
    .cfg_fire (cfg_valid && cfg_ready),
    .cfg_mode (cfg_data),
    .push     (push),
    .cmd      (cmd)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wdata      (cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: rtl/jsu_front.sv
// jsu_front: takes input bytes, tracks string/escape/\u state, issues one command
// per byte that yields results. Depends on jsu_pkg.
module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  jsu_pkg::in_item_t in_item,
  input  logic             cfg_fire,
  input  logic             cfg_mode,
  output logic             push,
  output jsu_pkg::cmd_t    cmd
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TEXT = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic        hex_stop_r, hex_stop_nxt;
  logic        mode_r;

  logic [7:0]  b;
  logic [7:0]  closer;
  logic [4:0]  hd;
  logic [15:0] cp_upd;

  assign b      = in_item.in_byte;
  assign closer = mode_r ? 8'h27 : 8'h22;
  assign hd     = jsu_pkg::hex_digit(b);
  assign cp_upd = (!hex_stop_r && hd[4]) ? {cp_r[11:0], hd[3:0]} : cp_r;

  always_comb begin
    phase_nxt    = phase_r;
    hex_cnt_nxt  = hex_cnt_r;
    cp_nxt       = cp_r;
    hex_stop_nxt = hex_stop_r;
    push         = 1'b0;
    cmd          = '0;
    if (in_fire) begin
      if (in_item.req_type) begin
        if (phase_r != PH_IDLE) begin
          push     = 1'b1;
          cmd.kind = jsu_pkg::CMD_UNTERM;
        end
        phase_nxt    = PH_IDLE;
        hex_cnt_nxt  = 2'd0;
        cp_nxt       = 16'd0;
        hex_stop_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_IDLE: begin
            phase_nxt = PH_TEXT;
          end
          PH_TEXT: begin
            if (b == closer) begin
              push      = 1'b1;
              cmd.kind  = jsu_pkg::CMD_CLOSE;
              phase_nxt = PH_IDLE;
            end else if (b == 8'h5C) begin
              phase_nxt = PH_ESC;
            end else begin
              push      = 1'b1;
              cmd.kind  = jsu_pkg::CMD_BYTE;
              cmd.value = {8'h00, b};
            end
          end
          PH_ESC: begin
            phase_nxt = PH_TEXT;
            push      = 1'b1;
            cmd.kind  = jsu_pkg::CMD_BYTE;
            if (b inside {8'h2F, 8'h5C, 8'h22}) begin
              cmd.value = {8'h00, b};
            end else begin
              case (b)
                8'h62: cmd.value = 16'h0008;
                8'h66: cmd.value = 16'h000C;
                8'h6E: cmd.value = 16'h000A;
                8'h72: cmd.value = 16'h000D;
                8'h74: cmd.value = 16'h0009;
                8'h75: begin
                  push         = 1'b0;
                  phase_nxt    = PH_HEX;
                  hex_cnt_nxt  = 2'd0;
                  cp_nxt       = 16'd0;
                  hex_stop_nxt = 1'b0;
                end
                default: cmd.kind = jsu_pkg::CMD_BADESC;
              endcase
            end
          end
          default: begin
            if (hex_cnt_r == 2'd3) begin
              push         = 1'b1;
              cmd.kind     = jsu_pkg::CMD_UTF8;
              cmd.value    = cp_upd;
              phase_nxt    = PH_TEXT;
              hex_cnt_nxt  = 2'd0;
              cp_nxt       = 16'd0;
              hex_stop_nxt = 1'b0;
            end else begin
              hex_cnt_nxt  = hex_cnt_r + 2'd1;
              cp_nxt       = cp_upd;
              hex_stop_nxt = hex_stop_r | ~hd[4];
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      hex_cnt_r  <= 2'd0;
      cp_r       <= 16'd0;
      hex_stop_r <= 1'b0;
      mode_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hex_cnt_r  <= hex_cnt_nxt;
      cp_r       <= cp_nxt;
      hex_stop_r <= hex_stop_nxt;
      if (cfg_fire) begin
        mode_r <= cfg_mode;
      end
    end
  end

endmodule

// File: rtl/jsu_fifo.sv
// jsu_fifo: small command queue between front and back, head read fall-through.
// Depends on jsu_pkg for cmd_t.
module jsu_fifo #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t wdata,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output jsu_pkg::cmd_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!push && pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: rtl/jsu_back.sv
// jsu_back: expands queued commands into result transfers (UTF-8 up to 3 beats)
// through an output register. Depends on jsu_pkg.
module jsu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  jsu_pkg::cmd_t     head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output jsu_pkg::out_item_t out_data
);

  logic [1:0]          beat_r;
  logic [1:0]          last_beat;
  logic                is_last;
  logic                load;
  logic                out_valid_r;
  jsu_pkg::out_item_t  out_data_r;
  jsu_pkg::out_item_t  res;
  logic [15:0]         cp;

  assign cp = head.value;

  always_comb begin
    last_beat = 2'd0;
    if (head.kind == jsu_pkg::CMD_UTF8) begin
      if (cp[15:11] != 5'd0) begin
        last_beat = 2'd2;
      end else if (cp[15:7] != 9'd0) begin
        last_beat = 2'd1;
      end
    end
  end

  assign is_last = (beat_r == last_beat);

  always_comb begin
    res             = '0;
    res.last_of_run = is_last;
    case (head.kind)
      jsu_pkg::CMD_BYTE: begin
        res.out_byte   = cp[7:0];
        res.byte_valid = 1'b1;
      end
      jsu_pkg::CMD_UTF8: begin
        res.byte_valid = 1'b1;
        if (last_beat == 2'd0) begin
          res.out_byte = cp[7:0];
        end else if (last_beat == 2'd1) begin
          res.out_byte = (beat_r == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
        end else begin
          case (beat_r)
            2'd0:    res.out_byte = {4'hE, cp[15:12]};
            2'd1:    res.out_byte = {2'b10, cp[11:6]};
            default: res.out_byte = {2'b10, cp[5:0]};
          endcase
        end
      end
      jsu_pkg::CMD_CLOSE: begin
        res.string_end = 1'b1;
        res.status     = jsu_pkg::STATUS_OK;
      end
      jsu_pkg::CMD_UNTERM: begin
        res.string_end = 1'b1;
        res.status     = jsu_pkg::STATUS_UNTERM;
      end
      jsu_pkg::CMD_BADESC: begin
        res.status = jsu_pkg::STATUS_BAD_ESC;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign load      = head_valid && (!out_valid_r || out_ready);
  assign pop       = load && is_last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        beat_r      <= is_last ? 2'd0 : beat_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r != 2'd3) else $error("beat counter out of range");
  a_mid_utf8: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r != 2'd0 |-> head_valid && head.kind == jsu_pkg::CMD_UTF8)
    else $error("multi-beat expansion lost its command");
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.byte_valid |-> out_data_r.out_byte == 8'h00)
    else $error("non-data result carries a byte");
  a_status_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != jsu_pkg::STATUS_OK |-> !out_data_r.byte_valid)
    else $error("status result carries a byte");
`endif

endmodule
